FILE: rtl/wcm_pkg.sv
// Shared types and constants for the window convolution MAC.
// Holds port field layout, item kinds and the control/result structs.
// No dependencies.
`default_nettype none

package wcm_pkg;

    // Field widths fixed by the stream layout
    localparam int SLOT_W      = 4;
    localparam int ROW_W       = 4;
    localparam int KSIZE_W     = 4;
    localparam int IN_VALUE_W  = 16;
    localparam int IN_LANES    = 9;
    localparam int OUT_SUM_W   = 38;

    // Slave tdata: kernel_slot, row_index, value_0 .. value_8 from bit 0 up
    localparam int SLOT_LSB    = 0;
    localparam int ROW_LSB     = SLOT_LSB + SLOT_W;
    localparam int VALUE_LSB   = ROW_LSB + ROW_W;
    localparam int S_TDATA_W   = VALUE_LSB + IN_LANES * IN_VALUE_W;

    // Master tdata: window_sum, used_slot, zero pad to whole bytes
    localparam int M_USED_W    = OUT_SUM_W + SLOT_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_USED_W;

    // Lower edge limit and reset value of the kernel size register
    localparam int                  EDGE_MIN    = 3;
    localparam logic [KSIZE_W-1:0]  KSIZE_RESET = 4'd3;

    // Result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_WINDOW = 1'b1
    } t_mode;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SLOT_W-1:0] slot;
    } t_ctl;

    typedef struct packed {
        logic [SLOT_W-1:0]           slot;
        logic signed [OUT_SUM_W-1:0] sum;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/wcm_lane.sv
// One multiplier lane: sample times coefficient, registered.
// Columns beyond the current edge give zero. Uses no package items.
`default_nettype none

module wcm_lane #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [VALUE_BITS-1:0]  i_sample,
    input  wire logic signed [VALUE_BITS-1:0]  i_coef,
    output logic signed [2*VALUE_BITS-1:0]     o_prod
);

    localparam int PROD_W = 2 * VALUE_BITS;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_sample) * PROD_W'(i_coef);
        end else begin
            r_prod <= '0;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/wcm_merge.sv
// Merging stage: registered adder tree over the lane products, then the
// saturating running sum. Depends on wcm_pkg for t_ctl, t_res and OUT_SUM_W.
`default_nettype none

module wcm_merge #(
    parameter int MAX_EDGE   = 9,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wcm_pkg::t_ctl                 i_ctl,
    input  wire logic signed [2*VALUE_BITS-1:0] i_prod [MAX_EDGE],
    output logic                               o_push,
    output wcm_pkg::t_res                      o_res,
    output logic [1:0]                         o_pend
);

    localparam int PROD_W    = 2 * VALUE_BITS;
    localparam int ROW_SUM_W = PROD_W + $clog2(MAX_EDGE);
    localparam int SUM_W     = 2 * VALUE_BITS - 1 + $clog2(MAX_EDGE * MAX_EDGE + 1);
    localparam int GROUPS    = (MAX_EDGE + 2) / 3;
    localparam longint LIMIT_L = longint'(MAX_EDGE * MAX_EDGE) <<< (2 * VALUE_BITS - 2);
    localparam logic signed [SUM_W:0] LIMIT     = (SUM_W + 1)'(LIMIT_L);
    localparam logic signed [SUM_W:0] NEG_LIMIT = -LIMIT;

    logic signed [ROW_SUM_W-1:0] n_pad [GROUPS*3];
    logic signed [ROW_SUM_W-1:0] n_part [GROUPS];
    logic signed [ROW_SUM_W-1:0] r_part [GROUPS];
    logic signed [ROW_SUM_W-1:0] n_row;
    logic signed [ROW_SUM_W-1:0] r_row;
    logic signed [SUM_W-1:0]     r_acc;
    logic signed [SUM_W:0]       n_total;
    logic signed [SUM_W:0]       n_clamp;
    wcm_pkg::t_ctl               r_ctl3;
    wcm_pkg::t_ctl               r_ctl4;

    // Pad the product row to whole groups of three
    for (genvar i = 0; i < GROUPS * 3; i++) begin : g_pad
        if (i < MAX_EDGE) begin : g_used
            assign n_pad[i] = ROW_SUM_W'(i_prod[i]);
        end else begin : g_zero
            assign n_pad[i] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_part[g] = n_pad[3*g] + n_pad[3*g+1] + n_pad[3*g+2];
        end
        n_row = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_row = n_row + r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_row  <= n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl3 <= i_ctl;
            r_ctl4 <= r_ctl3;
        end
    end

    // Add the row to the running sum and clamp to the window limit
    always_comb begin
        n_total = (SUM_W + 1)'(r_acc) + (SUM_W + 1)'(r_row);
        if (n_total > LIMIT) begin
            n_clamp = LIMIT;
        end else if (n_total < NEG_LIMIT) begin
            n_clamp = NEG_LIMIT;
        end else begin
            n_clamp = n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_ctl4.valid) begin
            // drop the sum once the window closes
            r_acc <= r_ctl4.last ? '0 : SUM_W'(n_clamp);
        end
    end

    assign o_push    = r_ctl4.valid && r_ctl4.last;
    assign o_res.sum = wcm_pkg::OUT_SUM_W'(n_clamp);
    assign o_res.slot = r_ctl4.slot;
    assign o_pend    = 2'(r_ctl3.valid && r_ctl3.last) + 2'(r_ctl4.valid && r_ctl4.last);

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl4.valid && r_ctl4.last) |=> (r_acc == '0))
        else $error("running sum not cleared after window close");

    a_acc_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((SUM_W + 1)'(r_acc) <= LIMIT) && ((SUM_W + 1)'(r_acc) >= NEG_LIMIT))
        else $error("running sum beyond saturation limit");

endmodule

`default_nettype wire

FILE: rtl/wcm_out_fifo.sv
// Result queue between the merging stage and the master stream side.
// Depends on wcm_pkg for t_res and the queue depth.
`default_nettype none

module wcm_out_fifo (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire wcm_pkg::t_res                     i_res,
    input  wire logic                              i_ready,
    output logic                                   o_valid,
    output wcm_pkg::t_res                          o_res,
    output logic [wcm_pkg::FIFO_CNT_W-1:0]         o_cnt
);

    wcm_pkg::t_res                   r_mem [wcm_pkg::FIFO_DEPTH];
    logic [wcm_pkg::FIFO_PTR_W-1:0]  r_wr;
    logic [wcm_pkg::FIFO_PTR_W-1:0]  r_rd;
    logic [wcm_pkg::FIFO_CNT_W-1:0]  r_cnt;
    logic                            n_pop;

    assign o_valid = (r_cnt != '0);
    assign n_pop   = o_valid && i_ready;
    assign o_res   = r_mem[r_rd];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (n_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + wcm_pkg::FIFO_CNT_W'(i_push) - wcm_pkg::FIFO_CNT_W'(n_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !n_pop && (r_cnt == wcm_pkg::FIFO_CNT_W'(wcm_pkg::FIFO_DEPTH))))
        else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: rtl/window_conv_mac.sv
// Window convolution MAC: one item per cycle, back to back, set by the single coefficient
// row read and the accumulate loop. A result enters the output queue once the row sum
// of the item that closes the window is registered; the input stalls only while the
// eight-entry queue and the results still in the pipeline leave no free slot. Synchronous
// active-low reset clears control, the running sum and the queue and sets kernel_size to 3;
// coefficient rows are not cleared. Uses wcm_pkg, wcm_lane, wcm_merge, wcm_out_fifo.
`default_nettype none

module window_conv_mac #(
    parameter int MAX_EDGE     = 9,
    parameter int KERNEL_COUNT = 9,
    parameter int VALUE_BITS   = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [wcm_pkg::KSIZE_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // kernel_slot, row_index, value_0 .. value_8
    input  wire logic [wcm_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // mode
    input  wire logic                              i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // window_sum, used_slot, zero pad
    output logic [wcm_pkg::M_TDATA_W-1:0]          o_m_tdata
);

    localparam int PROD_W     = 2 * VALUE_BITS;
    localparam int ROW_BITS   = MAX_EDGE * VALUE_BITS;
    localparam int STORE_ROWS = KERNEL_COUNT * MAX_EDGE;
    localparam int ADDR_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int KS_W       = wcm_pkg::KSIZE_W;

    logic [KS_W-1:0]                  r_ksize;
    logic                             r_run;
    logic [KS_W:0]                    n_odd;
    logic [KS_W-1:0]                  n_edge;
    logic                             n_acc;
    logic [wcm_pkg::SLOT_W-1:0]       n_slot;
    logic [wcm_pkg::ROW_W-1:0]        n_row;
    logic                             n_slot_ok;
    logic                             n_load_ok;
    logic                             n_win_ok;
    logic [ADDR_W-1:0]                n_addr;
    logic [ROW_BITS-1:0]              n_wr_row;
    logic [ROW_BITS-1:0]              r_coef_mem [STORE_ROWS];
    logic [ROW_BITS-1:0]              r_coef_row;
    logic signed [VALUE_BITS-1:0]     r_smp [MAX_EDGE];
    logic [MAX_EDGE-1:0]              r_mask;
    wcm_pkg::t_ctl                    r_ctl1;
    wcm_pkg::t_ctl                    r_ctl2;
    logic signed [PROD_W-1:0]         w_prod [MAX_EDGE];
    logic                             w_push;
    wcm_pkg::t_res                    w_res;
    wcm_pkg::t_res                    w_out;
    logic [1:0]                       w_pend;
    logic [wcm_pkg::FIFO_CNT_W-1:0]   w_cnt;
    logic [wcm_pkg::FIFO_CNT_W-1:0]   n_reserved;

    // Effective edge: even sizes lowered by one, then clamped
    always_comb begin
        n_odd = {1'b0, r_ksize} - {{KS_W{1'b0}}, ~r_ksize[0]};
        if (n_odd[KS_W] || (n_odd < (KS_W + 1)'(wcm_pkg::EDGE_MIN))) begin
            n_edge = KS_W'(wcm_pkg::EDGE_MIN);
        end else if (n_odd > (KS_W + 1)'(MAX_EDGE)) begin
            n_edge = KS_W'(MAX_EDGE);
        end else begin
            n_edge = n_odd[KS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize <= wcm_pkg::KSIZE_RESET;
            r_run   <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                r_ksize <= i_cfg_wdata;
            end
        end
    end

    // Hold a queue slot for every window-closing item in flight
    assign n_reserved = w_cnt
                      + wcm_pkg::FIFO_CNT_W'(r_ctl1.valid && r_ctl1.last)
                      + wcm_pkg::FIFO_CNT_W'(r_ctl2.valid && r_ctl2.last)
                      + wcm_pkg::FIFO_CNT_W'(w_pend);
    assign o_s_tready = r_run && (n_reserved < wcm_pkg::FIFO_CNT_W'(wcm_pkg::FIFO_DEPTH));
    assign n_acc      = i_s_tvalid && o_s_tready;

    assign n_slot    = i_s_tdata[wcm_pkg::SLOT_LSB +: wcm_pkg::SLOT_W];
    assign n_row     = i_s_tdata[wcm_pkg::ROW_LSB +: wcm_pkg::ROW_W];
    assign n_slot_ok = ({1'b0, n_slot} < (wcm_pkg::SLOT_W + 1)'(KERNEL_COUNT));
    assign n_load_ok = n_acc && (i_s_tuser == wcm_pkg::MODE_LOAD) && n_slot_ok
                     && ({1'b0, n_row} < (wcm_pkg::ROW_W + 1)'(MAX_EDGE));
    assign n_win_ok  = n_acc && (i_s_tuser == wcm_pkg::MODE_WINDOW) && n_slot_ok
                     && (n_row < n_edge);
    assign n_addr    = ADDR_W'(n_slot) * ADDR_W'(MAX_EDGE) + ADDR_W'(n_row);

    always_comb begin
        for (int l = 0; l < MAX_EDGE; l++) begin
            n_wr_row[l*VALUE_BITS +: VALUE_BITS] =
                i_s_tdata[wcm_pkg::VALUE_LSB + l*wcm_pkg::IN_VALUE_W +: VALUE_BITS];
        end
    end

    // Coefficient store: one row written or read per item
    always_ff @(posedge i_clk) begin
        if (n_load_ok) begin
            r_coef_mem[n_addr] <= n_wr_row;
        end
        if (n_win_ok) begin
            r_coef_row <= r_coef_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < MAX_EDGE; l++) begin
            r_smp[l]  <= i_s_tdata[wcm_pkg::VALUE_LSB + l*wcm_pkg::IN_VALUE_W +: VALUE_BITS];
            r_mask[l] <= (KS_W'(l) < n_edge);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1.valid <= n_win_ok;
            r_ctl1.last  <= (n_row == (n_edge - 1'b1));
            r_ctl1.slot  <= n_slot;
            r_ctl2       <= r_ctl1;
        end
    end

    for (genvar l = 0; l < MAX_EDGE; l++) begin : g_lane
        wcm_lane #(
            .VALUE_BITS (VALUE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (r_mask[l]),
            .i_sample (r_smp[l]),
            .i_coef   ($signed(r_coef_row[l*VALUE_BITS +: VALUE_BITS])),
            .o_prod   (w_prod[l])
        );
    end

    wcm_merge #(
        .MAX_EDGE   (MAX_EDGE),
        .VALUE_BITS (VALUE_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl2),
        .i_prod  (w_prod),
        .o_push  (w_push),
        .o_res   (w_res),
        .o_pend  (w_pend)
    );

    wcm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (w_out),
        .o_cnt   (w_cnt)
    );

    assign o_m_tdata = {{wcm_pkg::M_PAD_W{1'b0}}, w_out.slot, w_out.sum};

    a_reserve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_reserved <= wcm_pkg::FIFO_CNT_W'(wcm_pkg::FIFO_DEPTH))
        else $error("more results in flight than queue slots");

    a_load_no_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_acc && (i_s_tuser == wcm_pkg::MODE_LOAD)) |=> !r_ctl1.valid)
        else $error("load item entered the window pipeline");

endmodule

`default_nettype wire

FILE: tb/window_conv_mac_tb.sv
// Testbench for window_conv_mac: streams coefficient rows and window rows, predicts
// each window sum from its own copy of the kernel bank and checks the result stream.
// Depends on wcm_pkg and the window_conv_mac RTL.
`timescale 1ns / 100ps

module window_conv_mac_tb;
    import wcm_pkg::*;

    localparam int     KERNELS      = 9;
    localparam int     EDGE_MAX     = 9;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     PHASES       = 20;
    localparam int     PHASE_ITEMS  = 75;
    localparam longint SUM_CAP      = longint'(EDGE_MAX * EDGE_MAX) <<< (2 * IN_VALUE_W - 2);

    typedef logic [IN_LANES*IN_VALUE_W-1:0] lanes_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [KSIZE_W-1:0]   i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;

    // Predicted block state
    logic signed [IN_VALUE_W-1:0] coeff_bank [KERNELS][EDGE_MAX][EDGE_MAX];
    bit                           row_loaded [KERNELS][EDGE_MAX];
    longint                       window_acc   = 0;
    logic [KSIZE_W-1:0]           kernel_size  = KSIZE_RESET;
    t_res                         expected_sums [$];

    int error_count  = 0;
    int useful_items = 0;
    int hold_request = 0;
    bit steady       = 1'b0;

    window_conv_mac #(
        .MAX_EDGE     (EDGE_MAX),
        .KERNEL_COUNT (KERNELS),
        .VALUE_BITS   (IN_VALUE_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic int window_edge(logic [KSIZE_W-1:0] ks);
        int e;
        e = int'(ks);
        if (e % 2 == 0) e = e - 1;
        if (e > EDGE_MAX) e = EDGE_MAX;
        if (e < EDGE_MIN) e = EDGE_MIN;
        return e;
    endfunction

    // Update the bank or the running sum for one accepted item
    function automatic void predict_row(t_mode mode, logic [SLOT_W-1:0] slot,
                                        logic [ROW_W-1:0] row, lanes_t vals);
        int     k;
        longint row_sum;
        t_res   res;
        k = window_edge(kernel_size);
        if (slot >= KERNELS) return;
        if (mode == MODE_LOAD) begin
            if (row >= EDGE_MAX) return;
            for (int c = 0; c < EDGE_MAX; c++)
                coeff_bank[slot][row][c] = vals[c*IN_VALUE_W +: IN_VALUE_W];
            row_loaded[slot][row] = 1'b1;
            useful_items++;
            return;
        end
        if (row >= k) return;
        useful_items++;
        row_sum = 0;
        for (int c = 0; c < k; c++)
            row_sum += longint'($signed(vals[c*IN_VALUE_W +: IN_VALUE_W]))
                       * longint'(coeff_bank[slot][row][c]);
        window_acc += row_sum;
        if (window_acc > SUM_CAP) window_acc = SUM_CAP;
        if (window_acc < -SUM_CAP) window_acc = -SUM_CAP;
        if (row == k - 1) begin
            res.sum  = window_acc[OUT_SUM_W-1:0];
            res.slot = slot;
            expected_sums = {expected_sums, res};
            window_acc = 0;
        end
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [IN_VALUE_W-1:0] rand_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return r[IN_VALUE_W-1:0];
        endcase
    endfunction

    function automatic lanes_t rand_lanes();
        lanes_t v;
        for (int c = 0; c < IN_LANES; c++)
            v[c*IN_VALUE_W +: IN_VALUE_W] = rand_value();
        return v;
    endfunction

    task automatic send_row(t_mode mode, logic [SLOT_W-1:0] slot,
                            logic [ROW_W-1:0] row, lanes_t vals);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {vals, row, slot};
        do @(posedge i_clk); while (!o_s_tready);
        predict_row(mode, slot, row, vals);
    endtask

    // Stop offering, wait for every pending result, then let the pipeline empty
    task automatic wait_results();
        i_s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_kernel_size(logic [KSIZE_W-1:0] ks);
        wait_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ks;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        kernel_size = ks;
    endtask

    // Load a coefficient row before any window row reads it
    task automatic ensure_row(int slot, int row);
        if (!row_loaded[slot][row])
            send_row(MODE_LOAD, slot[SLOT_W-1:0], row[ROW_W-1:0], rand_lanes());
    endtask

    task automatic window_in_order(int slot, int k);
        for (int r = 0; r < k; r++) ensure_row(slot, r);
        for (int r = 0; r < k; r++)
            send_row(MODE_WINDOW, slot[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
    endtask

    task automatic send_noise(int k);
        int s;
        int r;
        case ($urandom_range(3))
            0: begin
                s = $urandom_range(15, KERNELS);
                r = $urandom_range(15);
                send_row(MODE_LOAD, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
            end
            1: begin
                s = $urandom_range(KERNELS - 1);
                r = $urandom_range(15, EDGE_MAX);
                send_row(MODE_LOAD, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
            end
            2: begin
                s = $urandom_range(15, KERNELS);
                r = $urandom_range(15);
                send_row(MODE_WINDOW, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
            end
            default: begin
                s = $urandom_range(KERNELS - 1);
                r = $urandom_range(15, k);
                if (r < EDGE_MAX) ensure_row(s, r);
                send_row(MODE_WINDOW, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
            end
        endcase
    endtask

    // Reset edge of 3, full-scale coefficients and samples, unused columns set
    task automatic test_reset_window();
        lanes_t mixed;
        mixed = {{6{16'h7fff}}, 16'h8001, 16'h0100, 16'hff00};
        send_row(MODE_LOAD, 4'd0, 4'd0, {IN_LANES{16'h7fff}});
        send_row(MODE_LOAD, 4'd0, 4'd1, {IN_LANES{16'h8000}});
        send_row(MODE_LOAD, 4'd0, 4'd2, mixed);
        send_row(MODE_WINDOW, 4'd0, 4'd0, {IN_LANES{16'h8000}});
        send_row(MODE_WINDOW, 4'd0, 4'd1, {IN_LANES{16'h8000}});
        send_row(MODE_WINDOW, 4'd0, 4'd2, mixed);
    endtask

    // Out-of-range slots and rows must leave the bank and the sum alone
    task automatic test_ignored_items();
        send_row(MODE_LOAD, 4'd9, 4'd0, {IN_LANES{16'h5555}});
        send_row(MODE_LOAD, 4'd15, 4'd15, {IN_LANES{16'haaaa}});
        send_row(MODE_LOAD, 4'd0, 4'd9, {IN_LANES{16'h1111}});
        send_row(MODE_WINDOW, 4'd15, 4'd2, {IN_LANES{16'h7fff}});
        send_row(MODE_WINDOW, 4'd0, 4'd15, {IN_LANES{16'h7fff}});
        send_row(MODE_WINDOW, 4'd0, 4'd0, {IN_LANES{16'h0001}});
        send_row(MODE_WINDOW, 4'd0, 4'd2, {IN_LANES{16'hffff}});
    endtask

    // Repeated full-scale rows drive the sum into both clamps
    task automatic test_saturation();
        set_kernel_size(4'd15);
        send_row(MODE_LOAD, 4'd8, 4'd0, {IN_LANES{16'h8000}});
        send_row(MODE_LOAD, 4'd8, 4'd8, {IN_LANES{16'h8000}});
        repeat (9) send_row(MODE_WINDOW, 4'd8, 4'd0, {IN_LANES{16'h8000}});
        send_row(MODE_WINDOW, 4'd8, 4'd8, {IN_LANES{16'h8000}});
        repeat (9) send_row(MODE_WINDOW, 4'd8, 4'd0, {IN_LANES{16'h7fff}});
        send_row(MODE_WINDOW, 4'd8, 4'd8, {IN_LANES{16'h7fff}});
    endtask

    // Hold the result side long enough for the queue to fill and stall the input
    task automatic test_backpressure();
        set_kernel_size(4'd3);
        for (int s = 0; s < KERNELS; s++)
            for (int r = 0; r < EDGE_MIN; r++) ensure_row(s, r);
        wait_results();
        steady       = 1'b1;
        hold_request = 300;
        for (int n = 0; n < 30; n++) window_in_order($urandom_range(KERNELS - 1), EDGE_MIN);
        wait_results();
        steady = 1'b0;
    endtask

    task automatic random_phase(int quota);
        int k;
        int s;
        int s2;
        int r;
        int n;
        int pick;
        int stop_at;
        k       = window_edge(kernel_size);
        stop_at = useful_items + quota;
        while (useful_items < stop_at) begin
            pick = $urandom_range(99);
            s    = $urandom_range(KERNELS - 1);
            if (pick < 55) begin
                window_in_order(s, k);
            end else if (pick < 67) begin
                // rows out of order, repeated, slots mixed, then the closing row
                n = $urandom_range(1, k + 2);
                repeat (n) begin
                    r  = $urandom_range(k - 2);
                    s2 = ($urandom_range(1) == 0) ? s : $urandom_range(KERNELS - 1);
                    ensure_row(s2, r);
                    send_row(MODE_WINDOW, s2[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
                end
                ensure_row(s, k - 1);
                r = k - 1;
                send_row(MODE_WINDOW, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
            end else if (pick < 77) begin
                r = $urandom_range(EDGE_MAX - 1);
                send_row(MODE_LOAD, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
            end else if (pick < 87) begin
                // window cut short: the partial sum carries into the next one
                n = $urandom_range(1, k - 1);
                for (r = 0; r < n; r++) begin
                    ensure_row(s, r);
                    send_row(MODE_WINDOW, s[SLOT_W-1:0], r[ROW_W-1:0], rand_lanes());
                end
            end else begin
                send_noise(k);
            end
        end
    endtask

    // Walk all sixteen register values, then random ones; every fourth phase runs flat out
    task automatic test_random_phases();
        int ks;
        for (int p = 0; p < PHASES; p++) begin
            ks = (p < 16) ? (3 + 7 * p) % 16 : $urandom_range(15);
            set_kernel_size(ks[KSIZE_W-1:0]);
            steady = (p % 4 == 3);
            random_phase(PHASE_ITEMS);
        end
        steady = 1'b0;
    endtask

    initial begin : result_side
        int                          stall_left;
        t_res                        want;
        logic signed [OUT_SUM_W-1:0] got_sum;
        logic [SLOT_W-1:0]           got_slot;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got_sum  = o_m_tdata[OUT_SUM_W-1:0];
                got_slot = o_m_tdata[OUT_SUM_W +: SLOT_W];
                if (expected_sums.size() == 0) begin
                    $error("unexpected result: window_sum %0d, used_slot %0d",
                           got_sum, got_slot);
                    error_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got_sum !== want.sum) begin
                        $error("window_sum: expected %0d, got %0d",
                               $signed(want.sum), got_sum);
                        error_count++;
                    end
                    if (got_slot !== want.slot) begin
                        $error("used_slot: expected %0d, got %0d", want.slot, got_slot);
                        error_count++;
                    end
                end
                if (o_m_tdata[M_TDATA_W-1:M_USED_W] !== '0) begin
                    $error("pad: expected 0, got %0h", o_m_tdata[M_TDATA_W-1:M_USED_W]);
                    error_count++;
                end
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_window();
        test_ignored_items();
        test_saturation();
        test_backpressure();
        test_random_phases();
        wait_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
